// ----- design/tlf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line folder package
// Shared constants, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package tlf_pkg;

  // Character bytes with a meaning of their own.
  localparam int unsigned CHAR_W = 8;
  localparam logic [CHAR_W-1:0] CHAR_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_SP  = 8'd32;

  // Default geometry.
  localparam int unsigned DEF_MAX_WIDTH = 48;
  localparam int unsigned DEF_TAB_WIDTH = 8;

  // Configuration port and register layout.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned FOLD_COL_W = 6;
  localparam logic [CFG_IDX_W-1:0]  REG_FOLD_COLUMN   = 8'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_FOLD_AT_BLANK = 8'd1;
  localparam logic [FOLD_COL_W-1:0] FOLD_COL_RESET    = 6'd48;
  localparam logic                  FOLD_BLANK_RESET  = 1'b1;

  // Source of an emitted byte.
  typedef enum logic [1:0] {
    EMIT_NL,
    EMIT_WORD,
    EMIT_CHAR
  } emit_sel_e;

  // Output beats that one input item calls for, in emission order.
  typedef struct packed {
    logic pre_nl;    // newline ahead of the word (wrap fold)
    logic do_word;   // drain the word buffer
    logic post_nl;   // newline after the word (newline input or hard fold)
    logic do_char;   // the blank or tab itself
    logic app_late;  // append the character after the drain
  } tlf_plan_t;

  typedef struct packed {
    tlf_plan_t plan;
    logic      drain_last;  // current drain byte is the final one
    logic      out_free;    // output register can take a beat
  } tlf_sts_t;

  typedef struct packed {
    logic      latch;      // capture the input beat
    logic      decide;     // commit the plan and update line state
    logic      emit;       // load the output register
    emit_sel_e sel;
    logic      last;
    logic      app_write;  // late append of the held character
  } tlf_cmd_t;

endpackage

// ----- design/text_line_folder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line folder
// Word-wrapping line folder on a byte stream with a register write port.
// ----------------------------------------------------------------------------
// One character byte comes in per input beat (tlast marks end of input) and
// the folded text leaves one byte per output beat, with tlast on the final
// byte an input beat caused. The block works on one input beat at a time: it
// accepts the beat, then makes the fold decision; each inserted newline or
// blank is one output load, each buffered character drained from the word
// memory takes a registered read of the memory, then the output load, and a
// fold that drains a buffered word and also buffers the new character ends
// with a separate write of that character. Output back-pressure can stall
// each output load. The word memory needs no clearing pass, so the block
// takes input right after reset. Registers: index 0 is the fold column
// (clamped to 1 through MaxWidth), index 1 selects folding at the last blank;
// other indices are ignored.
module text_line_folder_core
  import tlf_pkg::*;
#(
  parameter int unsigned MaxWidth = DEF_MAX_WIDTH,
  parameter int unsigned TabWidth = DEF_TAB_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] in_char
  input  logic                  s_axis_tlast,   // end_of_input
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [CHAR_W-1:0]     m_axis_tdata,   // [7:0] out_char
  output logic                  m_axis_tlast,   // last_in_run
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  tlf_cmd_t cmd;
  tlf_sts_t sts;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  tlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tlf_datapath #(
    .MaxWidth (MaxWidth),
    .TabWidth (TabWidth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_char_i   (s_axis_tdata),
    .in_eoi_i    (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- design/tlf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line folder controller
// Sequences the output beats of one input item and drives the datapath.
// ----------------------------------------------------------------------------
module tlf_ctrl
  import tlf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tlf_sts_t sts_i,
  output tlf_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PRE_NL,
    ST_WORD_RD,
    ST_WORD_OUT,
    ST_POST_NL,
    ST_CHAR,
    ST_APPEND
  } state_e;

  state_e    state_q, state_d;
  tlf_plan_t plan_q, plan;
  state_e    after_pre, after_word, after_post, after_char;
  logic      last_pre, last_word, last_post;

  // The plan is fresh from the datapath in the decide cycle, held after that.
  assign plan = (state_q == ST_DECIDE) ? sts_i.plan : plan_q;

  // Phase chaining: each phase falls through to the next one that is needed.
  always_comb begin
    after_char = plan.app_late ? ST_APPEND : ST_IDLE;
    after_post = plan.do_char ? ST_CHAR : after_char;
    after_word = plan.post_nl ? ST_POST_NL : after_post;
    after_pre  = plan.do_word ? ST_WORD_RD : after_word;
    last_pre   = !plan.do_word && !plan.post_nl && !plan.do_char;
    last_word  = sts_i.drain_last && !plan.post_nl && !plan.do_char;
    last_post  = !plan.do_char;
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = EMIT_NL;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = plan.pre_nl ? ST_PRE_NL : after_pre;
      end
      ST_PRE_NL: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_NL;
          cmd_o.last = last_pre;
          state_d    = after_pre;
        end
      end
      ST_WORD_RD: begin
        state_d = ST_WORD_OUT;
      end
      ST_WORD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_WORD;
          cmd_o.last = last_word;
          state_d    = sts_i.drain_last ? after_word : ST_WORD_RD;
        end
      end
      ST_POST_NL: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_NL;
          cmd_o.last = last_post;
          state_d    = after_post;
        end
      end
      ST_CHAR: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = EMIT_CHAR;
          cmd_o.last = 1'b1;
          state_d    = after_char;
        end
      end
      ST_APPEND: begin
        cmd_o.app_write = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and held plan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      plan_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DECIDE) begin
        plan_q <= sts_i.plan;
      end
    end
  end

endmodule

// ----- design/tlf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line folder datapath
// Line state, fold decision, word memory and output register.
// ----------------------------------------------------------------------------
module tlf_datapath
  import tlf_pkg::*;
#(
  parameter int unsigned MaxWidth = DEF_MAX_WIDTH,
  parameter int unsigned TabWidth = DEF_TAB_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [CHAR_W-1:0]     in_char_i,
  input  logic                  in_eoi_i,
  input  tlf_cmd_t              cmd_i,
  output tlf_sts_t              sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CHAR_W-1:0]     out_char_o,
  output logic                  out_last_o
);

  localparam int unsigned ColW     = $clog2(MaxWidth + 1);
  localparam int unsigned CalcW    = $clog2(MaxWidth + TabWidth + 1);
  localparam int unsigned AddrW    = $clog2(MaxWidth);
  localparam int unsigned NumStops = MaxWidth / TabWidth + 1;

  // Column after one character: next tab stop or one step on.
  function automatic logic [CalcW-1:0] advance(input logic [ColW-1:0] col, input logic tab);
    logic [CalcW-1:0] r;
    r = CalcW'(col) + CalcW'(1);
    if (tab) begin
      for (int k = NumStops; k >= 1; k--) begin
        if (CalcW'(k * TabWidth) > CalcW'(col)) begin
          r = CalcW'(k * TabWidth);
        end
      end
    end
    return r;
  endfunction

  logic [FOLD_COL_W-1:0] fold_col_q;
  logic                  fold_blank_q;
  logic [CHAR_W-1:0]     char_q;
  logic                  eoi_q;
  logic [ColW-1:0]       column_q, word_len_q, drain_len_q, rd_idx_q;
  logic                  blank_q;
  logic [CHAR_W-1:0]     word_mem_q [MaxWidth];
  logic [CHAR_W-1:0]     rd_data_q;
  logic                  out_valid_q, out_last_q;
  logic [CHAR_W-1:0]     out_char_q;

  logic [ColW-1:0]   lim, col_next, base;
  logic [CalcW-1:0]  lim_x, nc0, adv_wl, adv_zero, nc;
  logic              is_tab, is_nl, is_blank, line_end;
  logic              fold, wrap, hard, append;
  tlf_plan_t         plan;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  logic [CHAR_W-1:0] emit_char;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_col_q   <= FOLD_COL_RESET;
      fold_blank_q <= FOLD_BLANK_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FOLD_COLUMN:   fold_col_q   <= cfg_data_i[FOLD_COL_W-1:0];
        REG_FOLD_AT_BLANK: fold_blank_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Held input beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      char_q <= in_char_i;
      eoi_q  <= in_eoi_i;
    end
  end

  // Effective limit, clamped to one through the buffer depth.
  always_comb begin
    if (fold_col_q > FOLD_COL_W'(MaxWidth)) begin
      lim = ColW'(MaxWidth);
    end else if (fold_col_q == '0) begin
      lim = ColW'(1);
    end else begin
      lim = ColW'(fold_col_q);
    end
    lim_x = CalcW'(lim);
  end

  // Fold decision for the held character.
  always_comb begin
    is_tab   = (char_q == CHAR_TAB);
    is_nl    = (char_q == CHAR_NL);
    is_blank = is_tab || (char_q == CHAR_SP);
    line_end = eoi_q || is_nl;
    nc0      = advance(column_q, is_tab);
    adv_wl   = advance(word_len_q, is_tab);
    adv_zero = advance('0, is_tab);
    fold     = !line_end && (column_q != '0) && (nc0 > lim_x);
    wrap     = fold && blank_q && fold_blank_q && (adv_wl <= lim_x);
    hard     = fold && !wrap;
    // A wrap restarts the line at the word, a hard fold at column zero.
    nc       = wrap ? adv_wl : (hard ? adv_zero : nc0);
    col_next = (nc > lim_x) ? lim : nc[ColW-1:0];
    base     = fold ? '0 : word_len_q;
    append   = !line_end && !is_blank && (base < ColW'(MaxWidth));

    plan.pre_nl   = wrap;
    plan.do_word  = (line_end || fold || is_blank) && (word_len_q != '0);
    plan.post_nl  = !eoi_q && (is_nl || hard);
    plan.do_char  = !line_end && is_blank;
    plan.app_late = append && plan.do_word;
  end

  assign sts_o.plan       = plan;
  assign sts_o.drain_last = ((rd_idx_q + ColW'(1)) == drain_len_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Line state and drain counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      word_len_q  <= '0;
      blank_q     <= 1'b0;
      drain_len_q <= '0;
      rd_idx_q    <= '0;
    end else if (cmd_i.decide) begin
      drain_len_q <= word_len_q;
      rd_idx_q    <= '0;
      if (line_end) begin
        column_q   <= '0;
        word_len_q <= '0;
        blank_q    <= 1'b0;
      end else begin
        column_q <= col_next;
        blank_q  <= is_blank || (blank_q && !fold);
        if (is_blank) begin
          word_len_q <= '0;
        end else if (append) begin
          word_len_q <= base + ColW'(1);
        end else begin
          word_len_q <= base;
        end
      end
    end else if (cmd_i.emit && (cmd_i.sel == EMIT_WORD)) begin
      rd_idx_q <= rd_idx_q + ColW'(1);
    end
  end

  // Word memory. A late append only follows a fold, so it lands at the head.
  assign wr_en   = (cmd_i.decide && append && !plan.do_word) || cmd_i.app_write;
  assign wr_addr = cmd_i.app_write ? '0 : base[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      word_mem_q[wr_addr] <= char_q;
    end
    rd_data_q <= word_mem_q[rd_idx_q[AddrW-1:0]];
  end

  // Output register.
  always_comb begin
    case (cmd_i.sel)
      EMIT_WORD: emit_char = rd_data_q;
      EMIT_CHAR: emit_char = char_q;
      default:   emit_char = CHAR_NL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_q <= emit_char;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

// ----- design/tlf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line folder checker
// Port-level properties of the folder, bound to the top level.
// ----------------------------------------------------------------------------
module tlf_checker
  import tlf_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [CHAR_W-1:0]     m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o
);

  // A stalled output beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // One item at a time: the input closes right after a beat is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input stayed open after an accepted beat");

  // While the input is open, any pending output beat ends its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("input open while a run is still being emitted");

  // Register writes are never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("register write stalled");

endmodule

bind text_line_folder_core tlf_checker u_tlf_checker (.*);

// ----- bench/text_line_folder_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line folder checker
// Watches the input, output and register channels of the line folder,
// predicts the folded byte stream and compares every output beat with it.
// ----------------------------------------------------------------------------
module text_line_folder_checker
  import tlf_pkg::*;
#(
  parameter int unsigned MaxWidth = DEF_MAX_WIDTH,
  parameter int unsigned TabWidth = DEF_TAB_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [CHAR_W-1:0]     s_data_i,      // [7:0] in_char
  input  logic                  s_last_i,      // end_of_input
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [CHAR_W-1:0]     m_data_i,      // [7:0] out_char
  input  logic                  m_last_i,      // last_in_run
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    wraps_o,
  output int                    hard_folds_o
);

  localparam int unsigned MAX_REPORTS = 50;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } folded_byte_t;

  // Bytes the folder still owes, oldest first.
  folded_byte_t expected_bytes[$];

  // Predicted line state and register copies.
  logic [FOLD_COL_W-1:0] line_col;
  logic [FOLD_COL_W-1:0] word_len;
  logic                  blank_on_line;
  logic [CHAR_W-1:0]     word_buf [MaxWidth];
  logic [FOLD_COL_W-1:0] fold_col_reg;
  logic                  wrap_enable;

  int fail_cnt;
  int checked_cnt;
  int wrap_cnt;
  int hard_cnt;

  function automatic void owe_byte(input logic [CHAR_W-1:0] b);
    folded_byte_t fb;
    fb.ch   = b;
    fb.last = 1'b0;
    expected_bytes.push_back(fb);
  endfunction

  function automatic void drain_word();
    for (int i = 0; i < word_len; i++) owe_byte(word_buf[i]);
    word_len = '0;
  endfunction

  // Column reached after placing one character at a given column.
  function automatic int unsigned next_col(input int unsigned col, input logic [CHAR_W-1:0] ch);
    if (ch == CHAR_TAB) return col / TabWidth * TabWidth + TabWidth;
    return col + 1;
  endfunction

  // Works out the bytes one input beat causes and updates the line state.
  function automatic void fold_char(input logic [CHAR_W-1:0] ch, input logic eoi);
    int unsigned  limit;
    int unsigned  nc;
    int unsigned  wl;
    int           first;
    folded_byte_t tail;
    first = expected_bytes.size();
    limit = 32'(fold_col_reg);
    if (limit < 1) limit = 1;
    if (limit > MaxWidth) limit = MaxWidth;
    if (eoi) begin
      // End of input flushes the word without a newline and clears everything.
      drain_word();
      line_col      = '0;
      blank_on_line = 1'b0;
      for (int i = 0; i < MaxWidth; i++) word_buf[i] = '0;
    end else if (ch == CHAR_NL) begin
      drain_word();
      owe_byte(CHAR_NL);
      line_col      = '0;
      blank_on_line = 1'b0;
    end else begin
      nc = next_col(32'(line_col), ch);
      if (line_col > 0 && nc > limit) begin
        // Wrap after the last blank only if the word and the new character fit.
        if (blank_on_line && wrap_enable && next_col(32'(word_len), ch) <= limit) begin
          wl = 32'(word_len);
          owe_byte(CHAR_NL);
          drain_word();
          line_col = FOLD_COL_W'(wl);
          wrap_cnt++;
        end else begin
          drain_word();
          owe_byte(CHAR_NL);
          line_col = '0;
          hard_cnt++;
        end
        blank_on_line = 1'b0;
        nc = next_col(32'(line_col), ch);
      end
      // A tab stop past the limit saturates at the limit.
      if (nc > limit) nc = limit;
      if (ch == CHAR_TAB || ch == CHAR_SP) begin
        drain_word();
        owe_byte(ch);
        blank_on_line = 1'b1;
      end else if (word_len < MaxWidth) begin
        word_buf[word_len] = ch;
        word_len++;
      end
      line_col = FOLD_COL_W'(nc);
    end
    // The final byte of this beat carries the run marker.
    if (expected_bytes.size() > first) begin
      tail      = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endfunction

  function automatic void report(input string what, input int exp_v, input int act_v);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    end else if (fail_cnt == MAX_REPORTS + 1) begin
      $display("%0t: further mismatch reports suppressed", $time);
    end
  endfunction

  // Compares one output beat with the oldest owed byte.
  function automatic void check_beat();
    folded_byte_t fb;
    if (expected_bytes.size() == 0) begin
      fail_cnt++;
      $display("%0t: output beat with nothing owed, expected none, actual out_char %0d last %0b",
               $time, m_data_i, m_last_i);
    end else begin
      fb = expected_bytes.pop_front();
      if (fb.ch !== m_data_i) report("out_char", fb.ch, m_data_i);
      if (fb.last !== m_last_i) report("last_in_run", fb.last, m_last_i);
      checked_cnt++;
    end
  endfunction

  // Output beats are checked before a new input beat is folded, so an output
  // and an input accepted at the same edge never race.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_bytes.delete();
      line_col      = '0;
      word_len      = '0;
      blank_on_line = 1'b0;
      for (int i = 0; i < MaxWidth; i++) word_buf[i] = '0;
      fold_col_reg  = FOLD_COL_RESET;
      wrap_enable   = FOLD_BLANK_RESET;
      fail_cnt      = 0;
      checked_cnt   = 0;
      wrap_cnt      = 0;
      hard_cnt      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
      wraps_o      <= 0;
      hard_folds_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) check_beat();
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_FOLD_COLUMN) fold_col_reg = cfg_data_i[FOLD_COL_W-1:0];
        else if (cfg_index_i == REG_FOLD_AT_BLANK) wrap_enable = cfg_data_i[0];
      end
      if (s_valid_i && s_ready_i) fold_char(s_data_i, s_last_i);
      fail_count_o <= fail_cnt;
      pending_o    <= expected_bytes.size();
      checked_o    <= checked_cnt;
      wraps_o      <= wrap_cnt;
      hard_folds_o <= hard_cnt;
    end
  end

endmodule

// ----- bench/text_line_folder_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text line folder testbench
// Drives text, end marks and register writes into the line folder, with
// random stalls on both streams, and lets the checker judge the output.
// ----------------------------------------------------------------------------
module text_line_folder_core_tb;
  import tlf_pkg::*;

  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned IDLE_LIMIT     = 3000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned END_CYCLES     = 20;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS    = 54;
  localparam int unsigned LAST_CFG_INDEX = (1 << CFG_IDX_W) - 1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [CHAR_W-1:0]     s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [CHAR_W-1:0]     m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int checked;
  int wraps;
  int hard_folds;

  // Stimulus bookkeeping and handshake shaping.
  int items_sent  = 0;
  int end_marks   = 0;
  int settings    = 0;
  int idle_cycles = 0;
  bit calm        = 1'b0;
  bit src_busy    = 1'b1;
  bit hold_req    = 1'b0;

  always #5 clk_i = ~clk_i;

  text_line_folder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  text_line_folder_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_last_i     (s_axis_tlast),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_last_i     (m_axis_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .wraps_o      (wraps),
    .hard_folds_o (hard_folds)
  );

  // Output sink: stalls in bursts during busy stretches, and once holds off
  // long enough for the folder to back up into its input.
  initial begin : sink
    int  stretch_left;
    bit  stalls_on;
    stretch_left = 0;
    stalls_on    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 80);
        stalls_on    = ($urandom_range(0, 2) != 0);
      end
      stretch_left--;
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm && stalls_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
        $display("FAIL text_line_folder_core");
        $finish;
      end
    end
  end

  // Offers one input beat, after an optional gap, and waits until it is taken.
  task automatic send_item(input logic [CHAR_W-1:0] ch, input logic eoi);
    if (!calm && src_busy && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (eoi) end_marks++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Lets every owed byte arrive, then a few more cycles for beats with no output.
  task automatic wait_idle(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Holds cfg_valid high; the caller lowers it after the last write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Writes both registers with random unused bits, plus an optional write
  // to an index the block does not decode.
  task automatic set_fold(input logic [FOLD_COL_W-1:0] col, input logic blank,
                          input bit stray);
    logic [CFG_DATA_W-1:0] d;
    d = $urandom_range(0, 255);
    d[FOLD_COL_W-1:0] = col;
    write_register(REG_FOLD_COLUMN, d);
    d = $urandom_range(0, 255);
    d[0] = blank;
    write_register(REG_FOLD_AT_BLANK, d);
    if (stray) begin
      write_register($urandom_range(REG_FOLD_AT_BLANK + 1, LAST_CFG_INDEX),
                     $urandom_range(0, 255));
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Random text: words of letters with some arbitrary bytes, separated by
  // blanks, tabs, newlines, end marks and the odd arbitrary byte.
  task automatic random_text(input int count);
    int word_left;
    int pick;
    word_left = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) src_busy = ($urandom_range(0, 2) != 0);
      if (word_left == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) send_item(CHAR_SP, 1'b0);
        else if (pick < 75) send_item(CHAR_TAB, 1'b0);
        else if (pick < 85) send_item(CHAR_NL, 1'b0);
        else if (pick < 90) send_item($urandom_range(0, 255), 1'b1);
        else send_item($urandom_range(0, 255), 1'b0);
        word_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                : $urandom_range(1, 10);
      end else begin
        // Lowercase letters mostly, any byte now and then.
        if ($urandom_range(0, 9) != 0) send_item(8'd97 + $urandom_range(0, 25), 1'b0);
        else send_item($urandom_range(0, 255), 1'b0);
        word_left--;
      end
    end
  endtask

  initial begin : stimulus
    logic [FOLD_COL_W-1:0] col;
    logic                  blank;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: empty end mark, extreme bytes, tab, blank, newline.
    send_item($urandom_range(0, 255), 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(CHAR_TAB, 1'b0);
    send_item(CHAR_SP, 1'b0);
    send_item(CHAR_NL, 1'b0);

    // Narrow line: a wrap after a blank, a tab to the limit, a wrap of an
    // empty word.
    wait_idle(SETTLE_CYCLES);
    set_fold(6'd8, 1'b1, 1'b0);
    send_text("ab cdefgh");
    send_item(CHAR_TAB, 1'b0);
    send_text("x");

    // Limit lowered under a long line: the wrapped word would not fit either.
    wait_idle(SETTLE_CYCLES);
    set_fold(6'd48, 1'b1, 1'b0);
    send_text(" abcd");
    wait_idle(SETTLE_CYCLES);
    set_fold(6'd2, 1'b1, 1'b0);
    send_text("e");

    // Limit clamped to one column, below the tab width.
    wait_idle(SETTLE_CYCLES);
    set_fold(6'd0, 1'b1, 1'b0);
    send_item(CHAR_TAB, 1'b0);
    send_item(CHAR_TAB, 1'b0);

    // Random text under a range of settings, extremes included.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle(SETTLE_CYCLES);
      case (p)
        0: begin col = 6'd48; blank = 1'b1; end
        1: begin col = 6'd8;  blank = 1'b1; end
        2: begin col = 6'd8;  blank = 1'b0; end
        3: begin col = 6'd0;  blank = 1'b1; end
        4: begin col = 6'd63; blank = 1'b0; end
        5: begin col = $urandom_range(8, 48); blank = 1'b1; end
        6: begin col = $urandom_range(0, 63); blank = $urandom_range(0, 1); end
        default: begin col = $urandom_range(8, 48); blank = 1'b1; end
      endcase
      set_fold(col, blank, p % 3 == 0);
      if (p == 2) hold_req = 1'b1;
      if (p == RANDOM_PHASES - 1) calm = 1'b1;
      random_text(PHASE_ITEMS);
    end

    wait_idle(END_CYCLES);
    $display("Sent %0d input beats (%0d end marks) under %0d register settings.",
             items_sent, end_marks, settings);
    $display("Checked %0d output beats, with %0d wrap folds and %0d hard folds.",
             checked, wraps, hard_folds);
    if (fail_count == 0) begin
      $display("PASS text_line_folder_core");
    end else begin
      $display("FAIL text_line_folder_core");
    end
    $finish;
  end

endmodule
